[rtl/xbr_pkg.sv]
`default_nettype none
package xbr_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned WARM_W = 5;
  localparam int unsigned DIV_CNT_W = 7;
  localparam int unsigned MUL_CNT_W = 2;
  localparam int unsigned WARMUP_STEPS_DEF = 20;

  localparam logic [WORD_W-1:0] SEED_SUBST = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] OUT_MULT = 64'h2545F4914F6CDD1D;

  localparam int unsigned SH_A = 12;
  localparam int unsigned SH_B = 25;
  localparam int unsigned SH_C = 27;

  localparam logic OP_RAW = 1'b0;
  localparam logic OP_BOUNDED = 1'b1;

  localparam logic [MUL_CNT_W-1:0] MUL_PH_LOW = 2'd3;
  localparam logic [MUL_CNT_W-1:0] MUL_PH_HI_X = 2'd2;
  localparam logic [MUL_CNT_W-1:0] MUL_PH_HI_C = 2'd1;
  localparam logic [MUL_CNT_W-1:0] MUL_PH_IDLE = 2'd0;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(WORD_W);

  typedef struct packed {
    logic latch;
    logic step;
    logic mul_start;
    logic div_start;
    logic div_sel_draw;
    logic lim_load;
    logic out_load;
  } xbr_cmd_t;

  typedef struct packed {
    logic op_bounded;
    logic bound_zero;
    logic mul_done;
    logic div_done;
    logic reject;
    logic out_free;
  } xbr_sts_t;

endpackage
`default_nettype wire

[rtl/xbr_ctrl.sv]
`default_nettype none
module xbr_ctrl #(
  parameter int unsigned WARMUP_STEPS = xbr_pkg::WARMUP_STEPS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire xbr_pkg::xbr_sts_t sts,
  output xbr_pkg::xbr_cmd_t     cmd
);
  import xbr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_WARM    = 8'b0000_0010,
    S_DECODE  = 8'b0000_0100,
    S_DIV_LIM = 8'b0000_1000,
    S_STEP    = 8'b0001_0000,
    S_MUL     = 8'b0010_0000,
    S_CHECK   = 8'b0100_0000,
    S_DIV_RES = 8'b1000_0000
  } state_t;

  localparam logic [WARM_W-1:0] WARM_INIT = WARM_W'(WARMUP_STEPS);
  localparam logic [WARM_W-1:0] WARM_LAST = WARM_W'(1);
  localparam state_t START_STATE = (WARMUP_STEPS == 0) ? S_IDLE : S_WARM;

  state_t            state_r, state_nxt;
  logic [WARM_W-1:0] warm_left_r, warm_left_nxt;
  logic              out_pend_r, out_pend_nxt;

  assign in_stall = (state_r != S_IDLE) || out_pend_r || cfg_we;

  always_comb begin
    state_nxt     = state_r;
    warm_left_nxt = warm_left_r;
    out_pend_nxt  = out_pend_r;
    cmd           = '0;
    if (out_pend_r && sts.out_free) begin
      cmd.out_load = 1'b1;
      out_pend_nxt = 1'b0;
    end
    if (cfg_we) begin
      state_nxt     = START_STATE;
      warm_left_nxt = WARM_INIT;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd.latch = 1'b1;
            state_nxt = S_DECODE;
          end
        end
        S_WARM: begin
          cmd.step      = 1'b1;
          warm_left_nxt = warm_left_r - WARM_W'(1);
          if (warm_left_r == WARM_LAST) begin
            state_nxt = S_IDLE;
          end
        end
        S_DECODE: begin
          if (!sts.op_bounded) begin
            state_nxt = S_STEP;
          end else if (sts.bound_zero) begin
            out_pend_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV_LIM;
          end
        end
        S_DIV_LIM: begin
          if (sts.div_done) begin
            cmd.lim_load = 1'b1;
            state_nxt    = S_STEP;
          end
        end
        S_STEP: begin
          cmd.step      = 1'b1;
          cmd.mul_start = 1'b1;
          state_nxt     = S_MUL;
        end
        S_MUL: begin
          if (sts.mul_done) begin
            state_nxt = S_CHECK;
          end
        end
        S_CHECK: begin
          if (!sts.op_bounded) begin
            out_pend_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else if (sts.reject) begin
            state_nxt = S_STEP;
          end else begin
            cmd.div_start    = 1'b1;
            cmd.div_sel_draw = 1'b1;
            state_nxt        = S_DIV_RES;
          end
        end
        S_DIV_RES: begin
          if (sts.div_done) begin
            out_pend_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= START_STATE;
      warm_left_r <= WARM_INIT;
      out_pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      warm_left_r <= warm_left_nxt;
      out_pend_r  <= out_pend_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/xbr_dp.sv]
`default_nettype none
module xbr_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [xbr_pkg::WORD_W-1:0]  cfg_seed,
  input  wire logic                        in_opcode,
  input  wire logic [xbr_pkg::WORD_W-1:0]  in_bound,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [xbr_pkg::WORD_W-1:0]  out_value,
  input  wire xbr_pkg::xbr_cmd_t           cmd,
  output xbr_pkg::xbr_sts_t                sts
);
  import xbr_pkg::*;

  logic [WORD_W-1:0]    gen_r, gen_nxt;
  logic                 op_r;
  logic [WORD_W-1:0]    bound_r;
  logic [WORD_W-1:0]    limit_r;
  logic [WORD_W-1:0]    prod_r;
  logic [MUL_CNT_W-1:0] mcnt_r;
  logic [WORD_W-1:0]    rem_r;
  logic [WORD_W-1:0]    dvd_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic                 out_valid_r;
  logic [WORD_W-1:0]    out_value_r;

  logic [WORD_W-1:0]    xs_a, xs_b;
  logic [HALF_W-1:0]    mul_a, mul_b;
  logic [WORD_W-1:0]    mul_p;
  logic [WORD_W:0]      div_t;
  logic                 div_ge;
  logic [WORD_W-1:0]    out_sel;

  // xorshift step
  always_comb begin
    xs_a    = gen_r ^ (gen_r >> SH_A);
    xs_b    = xs_a ^ (xs_a << SH_B);
    gen_nxt = xs_b ^ (xs_b >> SH_C);
  end

  // one 32x32 multiplier shared over three phases, low 64 bits only
  always_comb begin
    unique case (mcnt_r)
      MUL_PH_LOW: begin
        mul_a = gen_r[HALF_W-1:0];
        mul_b = OUT_MULT[HALF_W-1:0];
      end
      MUL_PH_HI_X: begin
        mul_a = gen_r[WORD_W-1:HALF_W];
        mul_b = OUT_MULT[HALF_W-1:0];
      end
      MUL_PH_HI_C: begin
        mul_a = gen_r[HALF_W-1:0];
        mul_b = OUT_MULT[WORD_W-1:HALF_W];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);
  end

  // restoring remainder, one bit per cycle
  assign div_t  = {rem_r, dvd_r[WORD_W-1]};
  assign div_ge = (div_t >= {1'b0, bound_r});

  always_comb begin
    if (!op_r) begin
      out_sel = prod_r;
    end else if (bound_r == '0) begin
      out_sel = '0;
    end else begin
      out_sel = rem_r;
    end
  end

  assign sts.op_bounded = op_r;
  assign sts.bound_zero = (bound_r == '0);
  assign sts.mul_done   = (mcnt_r == MUL_PH_IDLE);
  assign sts.div_done   = (dcnt_r == '0);
  assign sts.reject     = (prod_r >= limit_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= SEED_SUBST;
    end else if (cfg_we) begin
      gen_r <= (cfg_seed != '0) ? cfg_seed : SEED_SUBST;
    end else if (cmd.step) begin
      gen_r <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= MUL_PH_IDLE;
    end else if (cmd.mul_start) begin
      mcnt_r <= MUL_PH_LOW;
    end else if (mcnt_r != MUL_PH_IDLE) begin
      mcnt_r <= mcnt_r - MUL_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mcnt_r == MUL_PH_LOW) begin
      prod_r <= mul_p;
    end else if (mcnt_r != MUL_PH_IDLE) begin
      prod_r[WORD_W-1:HALF_W] <= prod_r[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= DIV_STEPS;
    end else if (dcnt_r != '0) begin
      dcnt_r <= dcnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      dvd_r <= cmd.div_sel_draw ? prod_r : '1;
    end else if (dcnt_r != '0) begin
      rem_r <= div_ge ? WORD_W'(div_t - {1'b0, bound_r}) : div_t[WORD_W-1:0];
      dvd_r <= {dvd_r[WORD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_opcode;
      bound_r <= in_bound;
    end
    // all-ones minus the remainder
    if (cmd.lim_load) begin
      limit_r <= ~rem_r;
    end
    if (cmd.out_load) begin
      out_value_r <= out_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[rtl/xorshift_bounded_random_top.sv]
`default_nettype none
// xorshift64* random source with unbiased bounded draws
// input channel: in_valid / in_stall, item = in_opcode, in_bound
//   in_opcode 0 returns a raw 64-bit draw, 1 returns a value in 0..in_bound-1
//   (in_bound 0 returns 0 and leaves the generator untouched)
// result channel: out_valid / out_stall, item = out_value, one per input item
// one item is worked on at a time; the next is taken once the result sits in
// the output register, even if the receiver still stalls it
// from accept to out_valid: a raw draw runs the xorshift step and three
//   passes of one shared 32x32 multiplier; a bounded draw adds a pass of the
//   bit-serial remainder unit for the rejection limit, a compare that retries
//   a rejected draw with a new step, and a second remainder pass for the result
// cfg_we loads cfg_seed (zero maps to a fixed constant) and reruns warmup;
// reset and each seed write hold in_stall high while the WARMUP_STEPS
// warmup steps run, one step per cycle
// a stalled result holds in the output register; at most one more item is
// taken meanwhile and its result waits until the register frees up
module xorshift_bounded_random_top #(
  parameter int unsigned WARMUP_STEPS = xbr_pkg::WARMUP_STEPS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [xbr_pkg::WORD_W-1:0] cfg_seed,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_opcode,
  input  wire logic [xbr_pkg::WORD_W-1:0] in_bound,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [xbr_pkg::WORD_W-1:0] out_value
);
  import xbr_pkg::*;

  xbr_cmd_t cmd;
  xbr_sts_t sts;

  xbr_ctrl #(
    .WARMUP_STEPS(WARMUP_STEPS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  xbr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_seed (cfg_seed),
    .in_opcode(in_opcode),
    .in_bound (in_bound),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .cmd      (cmd),
    .sts      (sts)
  );

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while previous one in progress");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (!sts.bound_zero && sts.op_bounded))
    else $error("remainder started with zero bound");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mul_start && cmd.div_start))
    else $error("multiplier and divider started together");

endmodule
`default_nettype wire

[verif/xbr_draw_checker.sv]
`timescale 1ns / 1ps

module xbr_draw_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [xbr_pkg::WORD_W-1:0] cfg_seed,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_opcode,
  input  logic [xbr_pkg::WORD_W-1:0] in_bound,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [xbr_pkg::WORD_W-1:0] out_value,
  output int unsigned                fault_count,
  output int unsigned                pending_draws
);
  import xbr_pkg::*;

  localparam logic [xbr_pkg::WORD_W-1:0] ALL_ONES = '1;

  logic [xbr_pkg::WORD_W-1:0] gen_state;
  logic [xbr_pkg::WORD_W-1:0] expected_values[$];
  int unsigned faults;

  function automatic logic [xbr_pkg::WORD_W-1:0] xorshift_next(
    input logic [xbr_pkg::WORD_W-1:0] s
  );
    logic [xbr_pkg::WORD_W-1:0] x;
    x = s;
    x = x ^ (x >> xbr_pkg::SH_A);
    x = x ^ (x << xbr_pkg::SH_B);
    x = x ^ (x >> xbr_pkg::SH_C);
    return x;
  endfunction

  task automatic load_seed(input logic [xbr_pkg::WORD_W-1:0] seed_val);
    gen_state = (seed_val != '0) ? seed_val : xbr_pkg::SEED_SUBST;
    repeat (xbr_pkg::WARMUP_STEPS_DEF) gen_state = xorshift_next(gen_state);
  endtask

  task automatic draw_value(
    input  logic                       op,
    input  logic [xbr_pkg::WORD_W-1:0] bnd,
    output logic [xbr_pkg::WORD_W-1:0] val
  );
    logic [xbr_pkg::WORD_W-1:0] ceiling;
    logic [xbr_pkg::WORD_W-1:0] r;
    if (op == OP_RAW) begin
      gen_state = xorshift_next(gen_state);
      val = gen_state * xbr_pkg::OUT_MULT;
    end else if (bnd == '0) begin
      val = '0;
    end else begin
      // largest multiple of the bound, draws at or above it are rejected
      ceiling = ALL_ONES - (ALL_ONES % bnd);
      do begin
        gen_state = xorshift_next(gen_state);
        r = gen_state * xbr_pkg::OUT_MULT;
      end while (r >= ceiling);
      val = r % bnd;
    end
  endtask

  always @(posedge clk) begin : monitor
    logic [xbr_pkg::WORD_W-1:0] want;
    if (!rst_n) begin
      load_seed('0);
      expected_values.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          if (faults < 10) $display("unexpected item value=%h at %0t", out_value, $time);
          faults++;
        end else begin
          want = expected_values.pop_front();
          if (out_value !== want) begin
            if (faults < 10) begin
              $display("value mismatch: expected %h actual %h at %0t", want, out_value, $time);
            end
            faults++;
          end
        end
      end
      if (cfg_we) load_seed(cfg_seed);
      if (in_valid && !in_stall) begin
        draw_value(in_opcode, in_bound, want);
        expected_values = {expected_values, want};
      end
    end
    fault_count <= faults;
    pending_draws <= $unsigned(expected_values.size());
  end

endmodule

[verif/tb_xorshift_bounded_random_top.sv]
`timescale 1ns / 1ps

module tb_xorshift_bounded_random_top;
  import xbr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned PHASE_ITEMS = 130;
  localparam logic [xbr_pkg::WORD_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic                       op;
    logic [xbr_pkg::WORD_W-1:0] bnd;
  } draw_req_t;

  localparam draw_req_t DIRECTED [18] = '{
    '{OP_RAW, 64'd0},
    '{OP_RAW, ALL_ONES},
    '{OP_BOUNDED, 64'd0},
    '{OP_RAW, 64'd0},
    '{OP_BOUNDED, 64'd1},
    '{OP_BOUNDED, 64'd2},
    '{OP_BOUNDED, 64'd3},
    '{OP_BOUNDED, 64'd10},
    '{OP_BOUNDED, 64'h0000_0001_0000_0000},
    '{OP_BOUNDED, 64'h8000_0000_0000_0000},
    '{OP_BOUNDED, 64'h8000_0000_0000_0001},
    '{OP_BOUNDED, 64'hC000_0000_0000_0000},
    '{OP_BOUNDED, 64'hFFFF_FFFF_FFFF_FFFE},
    '{OP_BOUNDED, ALL_ONES},
    '{OP_BOUNDED, 64'h5555_5555_5555_5555},
    '{OP_BOUNDED, 64'hAAAA_AAAA_AAAA_AAAA},
    '{OP_BOUNDED, 64'd0},
    '{OP_RAW, 64'h5555_5555_5555_5555}
  };

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [xbr_pkg::WORD_W-1:0] cfg_seed = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_opcode = OP_RAW;
  logic [xbr_pkg::WORD_W-1:0] in_bound = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [xbr_pkg::WORD_W-1:0] out_value;

  int unsigned fault_count;
  int unsigned pending_draws;
  int unsigned cycle_count = 0;
  bit          hold_req = 1'b0;
  bit          holding = 1'b0;

  xorshift_bounded_random_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_seed  (cfg_seed),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_bound  (in_bound),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value)
  );

  xbr_draw_checker draw_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_seed      (cfg_seed),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_bound      (in_bound),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .fault_count   (fault_count),
    .pending_draws (pending_draws)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [xbr_pkg::WORD_W-1:0] pick_bound();
    int unsigned roll;
    logic [xbr_pkg::WORD_W-1:0] wide;
    roll = $urandom_range(0, 99);
    wide = {$urandom, $urandom};
    if (roll < 5) return '0;
    if (roll < 35) return 64'($urandom_range(1, 16));
    if (roll < 50) return 64'd1 << $urandom_range(0, 63);
    // upper half bounds reject often
    if (roll < 62) return {1'b1, wide[62:0]};
    if (roll < 72) return ALL_ONES - 64'($urandom_range(0, 15));
    return wide >> $urandom_range(0, 63);
  endfunction

  task automatic send_item(input logic op, input logic [xbr_pkg::WORD_W-1:0] bnd);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_bound <= bnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap();
    int unsigned g;
    g = pick_gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_draws != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [xbr_pkg::WORD_W-1:0] s);
    cfg_seed <= s;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : result_side
    int unsigned g;
    forever begin
      if (hold_req) begin
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holding = 1'b0;
        hold_req = 1'b0;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        g = pick_gap();
        if (g != 0) begin
          out_stall <= 1'b1;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [xbr_pkg::WORD_W-1:0] seeds [5];
    seeds[0] = '0;
    seeds[1] = ALL_ONES;
    seeds[2] = 64'd1;
    seeds[3] = {$urandom, $urandom};
    seeds[4] = {1'b1, 31'($urandom), $urandom};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[k]) begin
      send_item(DIRECTED[k].op, DIRECTED[k].bnd);
      sender_gap();
    end
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      write_seed(seeds[p]);
      if (p == 2) begin
        // receiver backs up while raw draws keep coming
        hold_req = 1'b1;
        while (!holding) @(posedge clk);
        for (int h = 0; h < 12; h++) send_item(OP_RAW, {$urandom, $urandom});
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(1'($urandom_range(0, 1)), pick_bound());
        sender_gap();
      end
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (fault_count == 0 && pending_draws == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/xbr_pkg.sv
rtl/xbr_ctrl.sv
rtl/xbr_dp.sv
rtl/xorshift_bounded_random_top.sv
verif/xbr_draw_checker.sv
verif/tb_xorshift_bounded_random_top.sv
